>>> sv/tmc_pkg.sv
// ----------------------------------------------------------------------------
// tmc_pkg
// Shared types and constants for the model-matrix composer: fixed-point
// widths of the rotation and scaling datapath, row codes and the tag that
// travels with each row down the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tmc_pkg;

  // Field widths.
  localparam int unsigned FIX_W  = 32;   // Q16.16 values
  localparam int unsigned QUAT_W = 16;   // Q2.14 quaternion components
  localparam int unsigned ROW_W  = 2;

  // Quaternion products are Q.28 in 32 bits; rotation entries need 35 bits.
  localparam int unsigned PROD_W = 2 * QUAT_W;
  localparam int unsigned ROT_W  = 35;

  // Rotation entry split: upper part (floor by 2^16) and lower 16 bits.
  localparam int unsigned LO_W   = 16;
  localparam int unsigned HI_W   = ROT_W - LO_W;          // 19
  localparam int unsigned HIP_W  = HI_W + FIX_W;          // 51
  localparam int unsigned LOP_W  = LO_W + 1 + FIX_W;      // 49
  localparam int unsigned PART_W = LOP_W - LO_W;          // 33
  localparam int unsigned SUM_W  = HIP_W + 1;             // 52
  localparam int unsigned FINE_SH = 12;
  localparam int unsigned QUO_W  = SUM_W - FINE_SH;       // 40

  // 1.0 in Q.28 and the rounding half of the Q.44 to Q16.16 step.
  localparam logic signed [ROT_W-1:0] ONE_Q28  = ROT_W'(64'sd268435456);
  localparam logic signed [LOP_W-1:0] HALF_Q28 = LOP_W'(64'sd134217728);

  // Row codes.
  localparam logic [ROW_W-1:0] ROW_0    = 2'd0;
  localparam logic [ROW_W-1:0] ROW_1    = 2'd1;
  localparam logic [ROW_W-1:0] ROW_LAST = 2'd2;

  // Static flag bits.
  localparam int unsigned FLAG_STATIC = 0;
  localparam int unsigned FLAG_FORCE  = 1;

  // Sideband that travels with one row through the pipeline.
  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic signed [FIX_W-1:0] trans;
    logic                    rend;
  } row_tag_t;

endpackage

`default_nettype wire

>>> sv/trs_model_matrix_compose.sv
// ----------------------------------------------------------------------------
// trs_model_matrix_compose
// Builds the upper three rows of the model matrix T*R*S from a translation,
// an unnormalized Q2.14 quaternion and a per-axis scale.
// ----------------------------------------------------------------------------
// Each accepted item gives three result items, rows 0, 1 and 2 in order, on
// consecutive cycles while the output side keeps ready high; a new item is
// taken while the last row of the current one is issued, set by the single
// row sequencer that feeds one row per cycle into the datapath while the
// pipeline is not stalled. An item that is static and not forced gives no
// result. Row 0 of an item passes, after the item is accepted, through the
// row sequencer, the quaternion product stage, the rotation entry stage, the
// split-scale multiply stage and the rounding/saturation stage that is the
// output register. A low out_ready stalls the whole pipeline without loss.
`default_nettype none

module trs_model_matrix_compose (
  input  wire                clk,
  input  wire                rst_n,
  // Input item channel.
  input  wire                in_valid,
  output logic               in_ready,
  input  wire signed [31:0]  in_translation_x,
  input  wire signed [31:0]  in_translation_y,
  input  wire signed [31:0]  in_translation_z,
  input  wire signed [15:0]  in_quat_w,
  input  wire signed [15:0]  in_quat_x,
  input  wire signed [15:0]  in_quat_y,
  input  wire signed [15:0]  in_quat_z,
  input  wire signed [31:0]  in_scale_x,
  input  wire signed [31:0]  in_scale_y,
  input  wire signed [31:0]  in_scale_z,
  input  wire        [1:0]   in_static_flags,
  input  wire                in_renderable,
  // Result item channel.
  output logic               out_valid,
  input  wire                out_ready,
  output logic       [1:0]   out_row_index,
  output logic signed [31:0] out_col_zero,
  output logic signed [31:0] out_col_one,
  output logic signed [31:0] out_col_two,
  output logic signed [31:0] out_col_three,
  output logic               out_last_row,
  output logic               out_bvh_dirty
);

  import tmc_pkg::*;

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  logic                     adv;
  logic                     in_accept;
  logic                     in_drop;

  // Row sequencer (holds one item).
  logic                     a_valid_r;
  logic [ROW_W-1:0]         a_row_r;
  logic signed [FIX_W-1:0]  a_trans_r [3];
  logic signed [QUAT_W-1:0] a_qw_r, a_qx_r, a_qy_r, a_qz_r;
  logic signed [FIX_W-1:0]  a_scale_r [3];
  logic                     a_rend_r;
  row_tag_t                 a_tag;

  // Quaternion product stage.
  logic signed [QUAT_W-1:0] op_a [6];
  logic signed [QUAT_W-1:0] op_b [6];
  logic                     s1_valid_r;
  row_tag_t                 s1_tag_r;
  logic signed [PROD_W-1:0] s1_prod_r [6];
  logic signed [FIX_W-1:0]  s1_scale_r [3];

  // Rotation entry stage.
  logic signed [ROT_W-1:0]  diag_nxt, a_p, a_m, b_p, b_m;
  logic signed [ROT_W-1:0]  rot_nxt [3];
  logic                     s2_valid_r;
  row_tag_t                 s2_tag_r;
  logic signed [ROT_W-1:0]  s2_rot_r [3];
  logic signed [FIX_W-1:0]  s2_scale_r [3];

  // Split multiply stage.
  logic                     s3_valid_r;
  row_tag_t                 s3_tag_r;
  logic signed [HIP_W-1:0]  s3_hi_r [3];
  logic signed [LOP_W-1:0]  s3_lo_r [3];

  // Rounding and saturation into the output register.
  logic signed [FIX_W-1:0]  col_nxt [3];
  logic                     out_valid_r;
  row_tag_t                 out_tag_r;
  logic signed [FIX_W-1:0]  out_col_r [3];

  // --------------------------------------------------------------------------
  // Handshake: the whole pipeline moves unless the output holds a row that is not taken.
  // --------------------------------------------------------------------------
  assign adv       = out_ready || !out_valid_r;
  assign in_ready  = adv && (!a_valid_r || (a_row_r == ROW_LAST));
  assign in_accept = in_valid && in_ready;
  assign in_drop   = in_static_flags[FLAG_STATIC] && !in_static_flags[FLAG_FORCE];

  // --------------------------------------------------------------------------
  // Row sequencer: loads an item and issues rows 0, 1, 2 on advancing cycles.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      a_row_r   <= ROW_0;
    end else if (adv) begin
      if (in_accept && !in_drop) begin
        a_valid_r <= 1'b1;
        a_row_r   <= ROW_0;
      end else if (a_valid_r && (a_row_r == ROW_LAST)) begin
        a_valid_r <= 1'b0;
      end else if (a_valid_r) begin
        a_row_r <= a_row_r + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && !in_drop) begin
      a_trans_r[0] <= in_translation_x;
      a_trans_r[1] <= in_translation_y;
      a_trans_r[2] <= in_translation_z;
      a_qw_r       <= in_quat_w;
      a_qx_r       <= in_quat_x;
      a_qy_r       <= in_quat_y;
      a_qz_r       <= in_quat_z;
      a_scale_r[0] <= in_scale_x;
      a_scale_r[1] <= in_scale_y;
      a_scale_r[2] <= in_scale_z;
      a_rend_r     <= in_renderable;
    end
  end

  // Operand pairs per row: two products for the diagonal, then two pairs.
  always_comb begin
    a_tag.row  = a_row_r;
    a_tag.rend = a_rend_r;
    case (a_row_r)
      ROW_0: begin
        a_tag.trans = a_trans_r[0];
        op_a[0] = a_qy_r; op_b[0] = a_qy_r;   // yy
        op_a[1] = a_qz_r; op_b[1] = a_qz_r;   // zz
        op_a[2] = a_qx_r; op_b[2] = a_qy_r;   // xy
        op_a[3] = a_qw_r; op_b[3] = a_qz_r;   // wz
        op_a[4] = a_qx_r; op_b[4] = a_qz_r;   // xz
        op_a[5] = a_qw_r; op_b[5] = a_qy_r;   // wy
      end
      ROW_1: begin
        a_tag.trans = a_trans_r[1];
        op_a[0] = a_qx_r; op_b[0] = a_qx_r;   // xx
        op_a[1] = a_qz_r; op_b[1] = a_qz_r;   // zz
        op_a[2] = a_qx_r; op_b[2] = a_qy_r;   // xy
        op_a[3] = a_qw_r; op_b[3] = a_qz_r;   // wz
        op_a[4] = a_qy_r; op_b[4] = a_qz_r;   // yz
        op_a[5] = a_qw_r; op_b[5] = a_qx_r;   // wx
      end
      default: begin
        a_tag.trans = a_trans_r[2];
        op_a[0] = a_qx_r; op_b[0] = a_qx_r;   // xx
        op_a[1] = a_qy_r; op_b[1] = a_qy_r;   // yy
        op_a[2] = a_qx_r; op_b[2] = a_qz_r;   // xz
        op_a[3] = a_qw_r; op_b[3] = a_qy_r;   // wy
        op_a[4] = a_qy_r; op_b[4] = a_qz_r;   // yz
        op_a[5] = a_qw_r; op_b[5] = a_qx_r;   // wx
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage 1: six quaternion products for the current row.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag_r   <= a_tag;
      s1_scale_r <= a_scale_r;
      for (int i = 0; i < 6; i++) begin
        s1_prod_r[i] <= op_a[i] * op_b[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: the three rotation entries of the row, Q.28.
  // --------------------------------------------------------------------------
  always_comb begin
    diag_nxt = ONE_Q28 - ((ROT_W'(s1_prod_r[0]) + ROT_W'(s1_prod_r[1])) <<< 1);
    a_p      = (ROT_W'(s1_prod_r[2]) + ROT_W'(s1_prod_r[3])) <<< 1;
    a_m      = (ROT_W'(s1_prod_r[2]) - ROT_W'(s1_prod_r[3])) <<< 1;
    b_p      = (ROT_W'(s1_prod_r[4]) + ROT_W'(s1_prod_r[5])) <<< 1;
    b_m      = (ROT_W'(s1_prod_r[4]) - ROT_W'(s1_prod_r[5])) <<< 1;
    case (s1_tag_r.row)
      ROW_0: begin
        rot_nxt[0] = diag_nxt;
        rot_nxt[1] = a_m;
        rot_nxt[2] = b_p;
      end
      ROW_1: begin
        rot_nxt[0] = a_p;
        rot_nxt[1] = diag_nxt;
        rot_nxt[2] = b_m;
      end
      default: begin
        rot_nxt[0] = a_m;
        rot_nxt[1] = b_p;
        rot_nxt[2] = diag_nxt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_tag_r   <= s1_tag_r;
      s2_scale_r <= s1_scale_r;
      s2_rot_r   <= rot_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: entry times scale as two partial products, upper and lower.
  // The upper part is the signed floor of the entry by 2^16.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_tag_r <= s2_tag_r;
      for (int c = 0; c < 3; c++) begin
        s3_hi_r[c] <= $signed(s2_rot_r[c][ROT_W-1:LO_W]) * s2_scale_r[c];
        s3_lo_r[c] <= $signed({1'b0, s2_rot_r[c][LO_W-1:0]}) * s2_scale_r[c];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: round to nearest (ties up), bring to Q16.16 and saturate.
  // --------------------------------------------------------------------------
  always_comb begin
    logic signed [LOP_W-1:0] lo_rnd;
    logic signed [SUM_W-1:0] sum;
    logic signed [QUO_W-1:0] quo;
    for (int c = 0; c < 3; c++) begin
      lo_rnd = s3_lo_r[c] + HALF_Q28;
      sum    = SUM_W'(s3_hi_r[c]) + SUM_W'($signed(lo_rnd[LOP_W-1:LO_W]));
      quo    = sum[SUM_W-1:FINE_SH];
      if ((&quo[QUO_W-1:FIX_W-1]) || !(|quo[QUO_W-1:FIX_W-1])) begin
        col_nxt[c] = quo[FIX_W-1:0];
      end else if (quo[QUO_W-1]) begin
        col_nxt[c] = {1'b1, {(FIX_W-1){1'b0}}};
      end else begin
        col_nxt[c] = {1'b0, {(FIX_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tag_r <= s3_tag_r;
      out_col_r <= col_nxt;
    end
  end

  // Valid bits travel with the rows.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= a_valid_r;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign out_valid     = out_valid_r;
  assign out_row_index = out_tag_r.row;
  assign out_col_zero  = out_col_r[0];
  assign out_col_one   = out_col_r[1];
  assign out_col_two   = out_col_r[2];
  assign out_col_three = out_tag_r.trans;
  assign out_last_row  = (out_tag_r.row == ROW_LAST);
  assign out_bvh_dirty = out_tag_r.rend;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Rows of one item leave back to back: after a row that is not the last
  // one is taken, the next row of the same item is already at the output.
  a_row_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_row) |=>
      (out_valid && (out_row_index == $past(out_row_index) + 2'd1)))
    else $error("row sequence broken at the output");

  // The dirty flag is a property of the item and stays across its rows.
  a_dirty_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_row) |=>
      (out_bvh_dirty == $past(out_bvh_dirty)))
    else $error("bvh dirty flag changed within one item");

  // No result is shown in the cycle after a reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// Model-matrix composer testbench
// Sends translation, quaternion and scale items through the composer and
// checks every row it returns against a local fixed-point prediction of
// T*R*S. Directed corner items come first, then random ones. Both channels
// idle at random in several phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tmc_pkg::*;

  // One transform item as it is presented on the input channel.
  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic [1:0]         flags;
    logic               rend;
  } xform_t;

  // One matrix row as it leaves the block.
  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] c3;
    logic               last;
    logic               dirty;
  } mrow_t;

  localparam longint ONE_FIX28 = 64'sd268435456;
  localparam int     RANDOM_XFORMS = 260;
  localparam int     PHASE_LEN = 45;
  localparam int     DRAIN_CYCLES = 16;

  typedef enum int {
    PH_STEADY,
    PH_SENDER_IDLE,
    PH_RECEIVER_STALL,
    PH_BOTH
  } idle_phase_t;

  logic clk;
  logic rst_n;

  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_translation_x;
  logic signed [31:0] in_translation_y;
  logic signed [31:0] in_translation_z;
  logic signed [15:0] in_quat_w;
  logic signed [15:0] in_quat_x;
  logic signed [15:0] in_quat_y;
  logic signed [15:0] in_quat_z;
  logic signed [31:0] in_scale_x;
  logic signed [31:0] in_scale_y;
  logic signed [31:0] in_scale_z;
  logic [1:0]         in_static_flags;
  logic               in_renderable;

  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_row_index;
  logic signed [31:0] out_col_zero;
  logic signed [31:0] out_col_one;
  logic signed [31:0] out_col_two;
  logic signed [31:0] out_col_three;
  logic               out_last_row;
  logic               out_bvh_dirty;

  xform_t      pending_xforms[$];
  mrow_t       expected_rows[$];
  xform_t      shown_xform;
  bit          xform_taken;
  bit          draining;
  int          xforms_sent;
  int          mismatches;
  idle_phase_t idle_phase;

  trs_model_matrix_compose u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_translation_x (in_translation_x),
    .in_translation_y (in_translation_y),
    .in_translation_z (in_translation_z),
    .in_quat_w        (in_quat_w),
    .in_quat_x        (in_quat_x),
    .in_quat_y        (in_quat_y),
    .in_quat_z        (in_quat_z),
    .in_scale_x       (in_scale_x),
    .in_scale_y       (in_scale_y),
    .in_scale_z       (in_scale_z),
    .in_static_flags  (in_static_flags),
    .in_renderable    (in_renderable),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_row_index    (out_row_index),
    .out_col_zero     (out_col_zero),
    .out_col_one      (out_col_one),
    .out_col_two      (out_col_two),
    .out_col_three    (out_col_three),
    .out_last_row     (out_last_row),
    .out_bvh_dirty    (out_bvh_dirty)
  );

  // Clock generation.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Rotation entry (Q.28) times scale (Q16.16), rounded half up to Q16.16
  // and saturated. The product is formed exactly in a wide vector.
  function automatic logic signed [31:0] scaled_entry(input longint rot,
                                                     input logic signed [31:0] scl);
    logic signed [95:0] rot_w;
    logic signed [95:0] scl_w;
    logic signed [95:0] prod;
    logic signed [95:0] quo;
    rot_w = rot;
    scl_w = scl;
    prod  = rot_w * scl_w + 96'sd134217728;
    quo   = prod >>> 28;
    if (quo > 96'sd2147483647) return 32'sh7FFFFFFF;
    if (quo < -96'sd2147483648) return 32'sh80000000;
    return quo[31:0];
  endfunction

  // Predicts the rows that one transform gives and queues them.
  function automatic void predict_matrix_rows(input xform_t x);
    longint w, i, j, k;
    longint rot[3][3];
    logic signed [31:0] trans[3];
    mrow_t r;
    if (x.flags[FLAG_STATIC] && !x.flags[FLAG_FORCE]) return;
    w = x.qw;
    i = x.qx;
    j = x.qy;
    k = x.qz;
    rot[0][0] = ONE_FIX28 - 2 * (j * j + k * k);
    rot[0][1] = 2 * (i * j - w * k);
    rot[0][2] = 2 * (i * k + w * j);
    rot[1][0] = 2 * (i * j + w * k);
    rot[1][1] = ONE_FIX28 - 2 * (i * i + k * k);
    rot[1][2] = 2 * (j * k - w * i);
    rot[2][0] = 2 * (i * k - w * j);
    rot[2][1] = 2 * (j * k + w * i);
    rot[2][2] = ONE_FIX28 - 2 * (i * i + j * j);
    trans[0] = x.tx;
    trans[1] = x.ty;
    trans[2] = x.tz;
    for (int n = 0; n < 3; n++) begin
      r.row   = ROW_W'(n);
      r.c0    = scaled_entry(rot[n][0], x.sx);
      r.c1    = scaled_entry(rot[n][1], x.sy);
      r.c2    = scaled_entry(rot[n][2], x.sz);
      r.c3    = trans[n];
      r.last  = (r.row == ROW_LAST);
      r.dirty = x.rend;
      expected_rows.push_back(r);
    end
  endfunction

  function automatic xform_t make_xform(input logic [31:0] t, input logic [15:0] qw,
                                        input logic [15:0] qx, input logic [15:0] qy,
                                        input logic [15:0] qz, input logic [31:0] s,
                                        input logic [1:0] flags, input logic rend);
    xform_t x;
    x.tx = t;
    x.ty = ~t;
    x.tz = t ^ 32'h5A5A_0F0F;
    x.qw = qw;
    x.qx = qx;
    x.qy = qy;
    x.qz = qz;
    x.sx = s;
    x.sy = s;
    x.sz = s;
    x.flags = flags;
    x.rend = rend;
    return x;
  endfunction

  function automatic logic [15:0] rand_quat_part();
    int v;
    v = $urandom_range(32768) - 16384;
    return v[15:0];
  endfunction

  function automatic logic [31:0] rand_scale();
    int pick;
    int v;
    pick = $urandom_range(99);
    if (pick < 50) begin
      // Within four units either side of zero.
      v = $urandom_range(524288) - 262144;
      return v;
    end
    if (pick < 65) return 32'h0001_0000;
    return $urandom;
  endfunction

  function automatic xform_t rand_xform();
    xform_t x;
    int pick;
    x.tx = $urandom;
    x.ty = $urandom;
    x.tz = $urandom;
    pick = $urandom_range(99);
    if (pick < 60) begin
      x.qw = rand_quat_part();
      x.qx = rand_quat_part();
      x.qy = rand_quat_part();
      x.qz = rand_quat_part();
    end else if (pick < 85) begin
      // Full 16-bit range, well outside unit length.
      x.qw = $urandom;
      x.qx = $urandom;
      x.qy = $urandom;
      x.qz = $urandom;
    end else begin
      // A half turn or identity about one axis.
      x.qw = 16'sd0;
      x.qx = 16'sd0;
      x.qy = 16'sd0;
      x.qz = 16'sd0;
      case ($urandom_range(3))
        0: x.qw = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        1: x.qx = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        2: x.qy = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        default: x.qz = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      endcase
    end
    x.sx = rand_scale();
    x.sy = rand_scale();
    x.sz = rand_scale();
    x.flags = $urandom_range(3);
    x.rend = $urandom_range(1);
    return x;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got %h, expected %h", name, got, want));
  endtask

  function automatic bit roll(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Driver: presents the next item or idles, and sets the receiver's ready.
  always @(negedge clk) begin
    if (rst_n) begin
      idle_phase = idle_phase_t'((xforms_sent / PHASE_LEN) % 4);
      if (!in_valid || xform_taken) begin
        if (pending_xforms.size() > 0 &&
            !((idle_phase == PH_SENDER_IDLE && roll(65)) ||
              (idle_phase == PH_BOTH && roll(11)))) begin
          shown_xform      <= pending_xforms[0];
          in_translation_x <= pending_xforms[0].tx;
          in_translation_y <= pending_xforms[0].ty;
          in_translation_z <= pending_xforms[0].tz;
          in_quat_w        <= pending_xforms[0].qw;
          in_quat_x        <= pending_xforms[0].qx;
          in_quat_y        <= pending_xforms[0].qy;
          in_quat_z        <= pending_xforms[0].qz;
          in_scale_x       <= pending_xforms[0].sx;
          in_scale_y       <= pending_xforms[0].sy;
          in_scale_z       <= pending_xforms[0].sz;
          in_static_flags  <= pending_xforms[0].flags;
          in_renderable    <= pending_xforms[0].rend;
          in_valid         <= 1'b1;
          void'(pending_xforms.pop_front());
          xforms_sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= draining ||
                   !((idle_phase == PH_RECEIVER_STALL && roll(65)) ||
                     (idle_phase == PH_BOTH && roll(11)));
    end
  end

  // Monitor: predicts rows for each accepted item and checks each row taken.
  always @(posedge clk) begin
    mrow_t want;
    xform_taken = rst_n && in_valid && in_ready;
    if (xform_taken) predict_matrix_rows(shown_xform);
    if (rst_n && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        note_mismatch($sformatf("row %0d arrived with nothing expected", out_row_index));
      end else begin
        want = expected_rows.pop_front();
        check_field("row_index", 32'(out_row_index), 32'(want.row));
        check_field("col_zero", out_col_zero, want.c0);
        check_field("col_one", out_col_one, want.c1);
        check_field("col_two", out_col_two, want.c2);
        check_field("col_three", out_col_three, want.c3);
        check_field("last_row", 32'(out_last_row), 32'(want.last));
        check_field("bvh_dirty", 32'(out_bvh_dirty), 32'(want.dirty));
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_translation_x = '0;
    in_translation_y = '0;
    in_translation_z = '0;
    in_quat_w = '0;
    in_quat_x = '0;
    in_quat_y = '0;
    in_quat_z = '0;
    in_scale_x = '0;
    in_scale_y = '0;
    in_scale_z = '0;
    in_static_flags = '0;
    in_renderable = 1'b0;
    shown_xform = '0;
    xform_taken = 1'b0;
    draining = 1'b0;
    xforms_sent = 0;
    mismatches = 0;
    idle_phase = PH_STEADY;

    // Identity, then each combination of the static and force flags.
    pending_xforms.push_back(make_xform(32'h0001_0000, 16'sd16384, 0, 0, 0,
                                        32'h0001_0000, 2'b00, 1'b1));
    pending_xforms.push_back(make_xform(32'h0002_8000, 16'sd16384, 0, 0, 0,
                                        32'h0001_0000, 2'b01, 1'b1));
    pending_xforms.push_back(make_xform(32'h0003_0000, 16'sd16384, 0, 0, 0,
                                        32'h0001_0000, 2'b11, 1'b0));
    pending_xforms.push_back(make_xform(32'hFFFF_0000, 16'sd16384, 0, 0, 0,
                                        32'h0002_0000, 2'b10, 1'b1));
    // Half turns about each axis and negative unit quaternion.
    pending_xforms.push_back(make_xform(32'h1234_5678, 0, 16'sd16384, 0, 0,
                                        32'h0003_0000, 2'b00, 1'b0));
    pending_xforms.push_back(make_xform(32'h8765_4321, 0, 0, 16'sd16384, 0,
                                        32'hFFFF_0000, 2'b00, 1'b1));
    pending_xforms.push_back(make_xform(32'h0BAD_F00D, 0, 0, 0, -16'sd16384,
                                        32'h0000_8000, 2'b00, 1'b1));
    pending_xforms.push_back(make_xform(32'h0000_0001, -16'sd16384, 0, 0, 0,
                                        32'h0001_0000, 2'b11, 1'b1));
    // Ninety degrees about z, non-unit and zero quaternions.
    pending_xforms.push_back(make_xform(32'h0000_0000, 16'sd11585, 0, 0, 16'sd11585,
                                        32'h0001_0000, 2'b00, 1'b1));
    pending_xforms.push_back(make_xform(32'h0010_0000, 16'sd8000, 16'sd3000,
                                        -16'sd5000, 16'sd100, 32'h0004_0000, 2'b00, 1'b0));
    pending_xforms.push_back(make_xform(32'h7FFF_FFFF, 0, 0, 0, 0,
                                        32'h7FFF_FFFF, 2'b00, 1'b1));
    // Field extremes, saturating products both ways.
    pending_xforms.push_back(make_xform(32'h8000_0000, 16'sh8000, 16'sh8000,
                                        16'sh8000, 16'sh8000, 32'h7FFF_FFFF, 2'b00, 1'b1));
    pending_xforms.push_back(make_xform(32'h7FFF_FFFF, 16'sh7FFF, 16'sh7FFF,
                                        16'sh7FFF, 16'sh7FFF, 32'h8000_0000, 2'b10, 1'b0));
    pending_xforms.push_back(make_xform(32'h8000_0000, 16'sh7FFF, 16'sh8000,
                                        16'sh7FFF, 16'sh8000, 32'h8000_0000, 2'b00, 1'b1));
    pending_xforms.push_back(make_xform(32'h0000_0000, 16'sd16384, 16'sd16384,
                                        16'sd16384, 16'sd16384, 32'h7FFF_FFFF, 2'b11, 1'b1));
    pending_xforms.push_back(make_xform(32'hFFFF_FFFF, -16'sd16384, -16'sd16384,
                                        -16'sd16384, -16'sd16384, 32'hFFFF_FFFF, 2'b00, 1'b0));
    // Tiny scales that round to zero or to one unit.
    pending_xforms.push_back(make_xform(32'h0000_0100, 16'sd16384, 0, 0, 0,
                                        32'h0000_0001, 2'b00, 1'b1));
    pending_xforms.push_back(make_xform(32'h0000_0200, 16'sd11585, 16'sd11585, 0, 0,
                                        32'hFFFF_FFFF, 2'b00, 1'b0));
    pending_xforms.push_back(make_xform(32'h0000_0300, 0, 0, 0, 0,
                                        32'h0000_0000, 2'b01, 1'b0));
    pending_xforms.push_back(make_xform(32'h0000_0400, 16'sd1, -16'sd1, 16'sd1, -16'sd1,
                                        32'h0000_0003, 2'b00, 1'b1));

    for (int n = 0; n < RANDOM_XFORMS; n++) pending_xforms.push_back(rand_xform());

    // Synchronous reset, released at a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every item to be taken and every row to arrive.
    while (pending_xforms.size() > 0 || in_valid || expected_rows.size() > 0)
      @(posedge clk);
    draining = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_rows.size() > 0)
      note_mismatch($sformatf("%0d rows never arrived", expected_rows.size()));
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
